FILE: rtl/dvru_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dvru_pkg - shared types and constants of the distance-vector route engine
// Router count, cost widths, memory request and relaxation control structs.
// ----------------------------------------------------------------------------
package dvru_pkg;

    localparam int ROUTERS = 16;
    localparam int IDX_W   = $clog2(ROUTERS);
    localparam int COST_W  = 7;
    localparam int SUM_W   = COST_W + 1;
    localparam int HOP_W   = 5;
    localparam int ROW_W   = ROUTERS * COST_W;

    localparam logic [COST_W-1:0] UNREACH     = 7'd100;
    localparam logic [ROW_W-1:0]  ROW_UNREACH = {ROUTERS{UNREACH}};
    localparam logic [HOP_W-1:0]  NO_HOP      = HOP_W'(ROUTERS);

    // input item kinds
    localparam logic KIND_LINK   = 1'b0;
    localparam logic KIND_VECTOR = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_OWN_ROUTER = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_SCAN_RD,
        S_SCAN,
        S_EMIT
    } dvru_state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LANE,
        OP_POISON
    } dvru_op_t;

    // one row of the vector memory holds one destination column of all routers
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [ROW_W-1:0] wr_data;
    } mem_req_t;

    typedef struct packed {
        logic start;
        logic step;
    } relax_ctl_t;

    function automatic logic [COST_W-1:0] lane_get(input logic [ROW_W-1:0] row,
                                                   input logic [IDX_W-1:0] idx);
        lane_get = row[idx*COST_W +: COST_W];
    endfunction

    function automatic logic [ROW_W-1:0] lane_set(input logic [ROW_W-1:0]  row,
                                                  input logic [IDX_W-1:0]  idx,
                                                  input logic [COST_W-1:0] val);
        logic [ROW_W-1:0] res;
        res = row;
        for (int k = 0; k < ROUTERS; k++)
        begin
            if (IDX_W'(k) == idx)
            begin
                res[k*COST_W +: COST_W] = val;
            end
        end
        lane_set = res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/dvru_vec_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dvru_vec_mem - advertised cost memory
// One row per destination, one lane per advertising router. Synchronous
// read, data in the next cycle; rows never written read as all unreachable.
// ----------------------------------------------------------------------------
module dvru_vec_mem (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dvru_pkg::mem_req_t        req,
    output logic [dvru_pkg::ROW_W-1:0]     rd_data
);
    import dvru_pkg::*;

    logic [ROW_W-1:0] mem [ROUTERS];
    logic [ROUTERS-1:0] vld_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic             rd_vld_reg;

    // write and read the row array
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // track written rows and the validity of the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    // substitute the reset value for rows never written
    assign rd_data = rd_vld_reg ? rd_data_reg : ROW_UNREACH;

endmodule
`default_nettype wire

FILE: rtl/dvru_relax.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dvru_relax - relaxation unit
// Adds link and advertised cost of one candidate per cycle and keeps the
// cheapest reachable sum and its hop; later candidates win ties.
// ----------------------------------------------------------------------------
module dvru_relax (
    input  wire logic                        clk,
    input  wire dvru_pkg::relax_ctl_t        ctl,
    input  wire logic [dvru_pkg::IDX_W-1:0]  cand,
    input  wire logic [dvru_pkg::COST_W-1:0] link,
    input  wire logic [dvru_pkg::COST_W-1:0] adv,
    output logic [dvru_pkg::COST_W-1:0]      best,
    output logic [dvru_pkg::HOP_W-1:0]       hop
);
    import dvru_pkg::*;

    logic [COST_W-1:0] best_reg;
    logic [COST_W-1:0] best_next;
    logic [HOP_W-1:0]  hop_reg;
    logic [HOP_W-1:0]  hop_next;
    logic [SUM_W-1:0]  sum;
    logic              take;

    // compare the candidate sum against the running best
    always_comb
    begin
        sum       = {1'b0, link} + {1'b0, adv};
        take      = (sum < {1'b0, UNREACH}) && (sum <= {1'b0, best_reg});
        best_next = best_reg;
        hop_next  = hop_reg;
        if (ctl.start)
        begin
            best_next = UNREACH;
            hop_next  = NO_HOP;
        end
        else if (ctl.step && take)
        begin
            best_next = sum[COST_W-1:0];
            hop_next  = HOP_W'(cand);
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        hop_reg  <= hop_next;
    end

    assign best = best_reg;
    assign hop  = hop_reg;

endmodule
`default_nettype wire

FILE: rtl/distance_vector_route_update_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// distance_vector_route_update_core - distance-vector route engine
// Keeps link costs and advertised vectors, recomputes routes on demand.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries link items and vector items.
//   An item is taken only while the engine is idle. A link item or a plain
//   vector item reads one memory row, modifies it and writes it back; a
//   poisoning vector item (cost 100) only writes the row as unreachable;
//   an ignored item is dropped. An item with last_entry set then starts
//   a recompute that walks every destination: a row read, a step through
//   the relaxation adder for each router, then a write-back. The walk is
//   sequential through the single adder of the relaxation unit and the
//   one memory port.
//   Output channel (out_valid/out_ready) delivers one transfer per
//   destination in ascending order, the final one flagged by last_route.
//   A waiting result sits in the output register; while the receiver stalls
//   the walk holds at the write-back of the next destination.
//   Reset clears all link costs and advertised costs to unreachable and sets
//   own_router to 0. own_router is written over the APB port at offset 0,
//   by the user only while the engine is idle; the block does not check it.
// ----------------------------------------------------------------------------
module distance_vector_route_update_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [3:0]  router,
    input  wire logic [3:0]  destination,
    input  wire logic [6:0]  cost,
    input  wire logic        last_entry,
    // output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       route_destination,
    output logic [6:0]       best_cost,
    output logic [4:0]       next_hop,
    output logic             changed,
    output logic             last_route
);
    import dvru_pkg::*;

    dvru_state_t       state_reg, state_next;
    dvru_op_t          op_reg, op_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [IDX_W-1:0]  lane_reg, lane_next;
    logic [COST_W-1:0] val_reg, val_next;
    logic              link_wr_reg, link_wr_next;
    logic              last_reg, last_next;
    logic [IDX_W-1:0]  d_reg, d_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  own_router_reg;
    logic [COST_W-1:0] link_cost_reg [ROUTERS];

    logic              out_valid_reg, out_valid_next;
    logic [3:0]        out_dest_reg, out_dest_next;
    logic [COST_W-1:0] out_cost_reg, out_cost_next;
    logic [HOP_W-1:0]  out_hop_reg, out_hop_next;
    logic              out_chg_reg, out_chg_next;
    logic              out_last_reg, out_last_next;

    mem_req_t          mem_req;
    logic [ROW_W-1:0]  rd_data;
    relax_ctl_t        relax_ctl;
    logic [COST_W-1:0] link_sel;
    logic [COST_W-1:0] adv_sel;
    logic [COST_W-1:0] best;
    logic [HOP_W-1:0]  hop;
    logic [COST_W-1:0] cost_sat;
    logic              in_fire;
    logic              cfg_wr;
    logic              rtr_ok;
    logic              dst_ok;
    logic              out_free;

    dvru_vec_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    dvru_relax u_relax (
        .clk  (clk),
        .ctl  (relax_ctl),
        .cand (j_reg),
        .link (link_sel),
        .adv  (adv_sel),
        .best (best),
        .hop  (hop)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_OWN_ROUTER) ? 32'(own_router_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_router_reg <= '0;
        end
        else if (cfg_wr && (paddr[2] == REG_OWN_ROUTER)
                 && ({1'b0, pwdata[3:0]} < 5'(ROUTERS)))
        begin
            own_router_reg <= IDX_W'(pwdata[3:0]);
        end
    end

    // candidate operands for the relaxation unit
    assign link_sel = (j_reg == own_router_reg) ? '0 : link_cost_reg[j_reg];
    assign adv_sel  = lane_get(rd_data, j_reg);

    assign cost_sat = (cost > UNREACH) ? UNREACH : cost;
    assign rtr_ok   = {1'b0, router} < 5'(ROUTERS);
    assign dst_ok   = {1'b0, destination} < 5'(ROUTERS);
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // next state, memory requests and result register
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        lane_next      = lane_reg;
        val_next       = val_reg;
        link_wr_next   = link_wr_reg;
        last_next      = last_reg;
        d_next         = d_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_dest_next  = out_dest_reg;
        out_cost_next  = out_cost_reg;
        out_hop_next   = out_hop_reg;
        out_chg_next   = out_chg_reg;
        out_last_next  = out_last_reg;
        mem_req        = '0;
        relax_ctl      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    last_next    = last_entry;
                    val_next     = cost_sat;
                    link_wr_next = 1'b0;
                    op_next      = OP_NONE;
                    addr_next    = IDX_W'(destination);
                    lane_next    = IDX_W'(router);
                    if (kind == KIND_LINK)
                    begin
                        if (rtr_ok)
                        begin
                            // own vector entry lies in the column of the neighbour
                            op_next      = OP_LANE;
                            addr_next    = IDX_W'(router);
                            lane_next    = own_router_reg;
                            link_wr_next = 1'b1;
                        end
                    end
                    else if (rtr_ok && dst_ok)
                    begin
                        op_next = (cost_sat == UNREACH) ? OP_POISON : OP_LANE;
                    end

                    if (kind == KIND_LINK ? rtr_ok : (rtr_ok && dst_ok))
                    begin
                        if (kind == KIND_VECTOR && cost_sat == UNREACH)
                        begin
                            state_next = S_LD_WR;
                        end
                        else
                        begin
                            state_next = S_LD_RD;
                        end
                    end
                    else if (last_entry)
                    begin
                        d_next     = '0;
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_LD_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = addr_reg;
                state_next      = S_LD_WR;
            end

            S_LD_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = addr_reg;
                mem_req.wr_data = (op_reg == OP_POISON) ? ROW_UNREACH
                                : lane_set(rd_data, lane_reg, val_reg);
                d_next          = '0;
                state_next      = last_reg ? S_SCAN_RD : S_IDLE;
            end

            S_SCAN_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = d_reg;
                relax_ctl.start = 1'b1;
                j_next          = IDX_W'(ROUTERS - 1);
                state_next      = S_SCAN;
            end

            S_SCAN:
            begin
                // walk from the top so the lowest index wins ties
                relax_ctl.step = 1'b1;
                j_next         = j_reg - 1'b1;
                if (j_reg == '0)
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_dest_next   = 4'(d_reg);
                    out_cost_next   = best;
                    out_hop_next    = hop;
                    out_chg_next    = (best != lane_get(rd_data, own_router_reg));
                    out_last_next   = (d_reg == IDX_W'(ROUTERS - 1));
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = d_reg;
                    mem_req.wr_data = lane_set(rd_data, own_router_reg, best);
                    if (d_reg == IDX_W'(ROUTERS - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        state_next = S_SCAN_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // link costs start unreachable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROUTERS; k++)
            begin
                link_cost_reg[k] <= UNREACH;
            end
        end
        else if (state_reg == S_LD_WR && link_wr_reg)
        begin
            link_cost_reg[addr_reg] <= val_reg;
        end
    end

    // item fields, walk counters and result payload
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        addr_reg     <= addr_next;
        lane_reg     <= lane_next;
        val_reg      <= val_next;
        link_wr_reg  <= link_wr_next;
        last_reg     <= last_next;
        d_reg        <= d_next;
        j_reg        <= j_next;
        out_dest_reg <= out_dest_next;
        out_cost_reg <= out_cost_next;
        out_hop_reg  <= out_hop_next;
        out_chg_reg  <= out_chg_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid         = out_valid_reg;
    assign route_destination = out_dest_reg;
    assign best_cost         = out_cost_reg;
    assign next_hop          = out_hop_reg;
    assign changed           = out_chg_reg;
    assign last_route        = out_last_reg;

`ifndef NO_ASSERTIONS
    // the single memory port never reads and writes in one cycle
    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("memory read and write in the same cycle");

    // a result is unreachable exactly when it names no hop
    a_no_route: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((best_cost == UNREACH) == (next_hop == NO_HOP)))
        else $error("best cost and next hop disagree on reachability");

    // the final result describes the last destination
    a_last_dest: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_route |-> (route_destination == 4'(ROUTERS - 1)))
        else $error("last_route on a destination other than the last");

    // a scan of one destination ends only in the write-back
    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |=> (state_reg == S_SCAN || state_reg == S_EMIT))
        else $error("scan left without write-back");

    // every scan is preceded by its row read
    a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_SCAN) |-> $past(state_reg) == S_SCAN_RD)
        else $error("scan started without row read");
`endif

endmodule
`default_nettype wire
